/* src/assert_macros.svh */
// assertion macros shared by the rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

/* src/ifmt_pkg.sv */
// types, codes and helpers of the integer to ascii formatter
// no dependencies
package ifmt_pkg;

	localparam logic [2:0] FUNC_BIN  = 3'd0;
	localparam logic [2:0] FUNC_SDEC = 3'd1;
	localparam logic [2:0] FUNC_OCT  = 3'd2;
	localparam logic [2:0] FUNC_UDEC = 3'd3;
	localparam logic [2:0] FUNC_HEXL = 3'd4;
	localparam logic [2:0] FUNC_HEXU = 3'd5;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [3:0] DEC_TEN    = 4'd10;

	// digit stack depth and bcd register width (20 decimal digits)
	localparam int DIG_DEPTH = 64;
	localparam logic [6:0] DIG_MAX = 7'd64;
	localparam int BCD_W = 80;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] value;
		logic        long_value;
		logic [6:0]  width;
		logic        left_adjust;
		logic        zero_pad;
	} fmt_req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} fmt_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DD   = 4'b0010,
		ST_DIG  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < DEC_TEN)
			c = CHAR_ZERO + {4'd0, d};
		else if (upper)
			c = CHAR_UA + {4'd0, d - DEC_TEN};
		else
			c = CHAR_LA + {4'd0, d - DEC_TEN};
		return c;
	endfunction

	function automatic logic [3:0] digit_mask(input logic [2:0] func);
		logic [3:0] m;
		case (func)
			FUNC_BIN: m = 4'b0001;
			FUNC_OCT: m = 4'b0111;
			default:  m = 4'b1111;
		endcase
		return m;
	endfunction

endpackage

/* src/ifmt_stream_if.sv */
// valid/ready channel carrying one payload struct per transaction
// payload types come from ifmt_pkg
interface ifmt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/integer_to_ascii_formatter_top.sv */
// integer to ascii formatter, printf style, one character per output transaction
// depends on ifmt_pkg, ifmt_stream_if and assert_macros.svh
//
// req carries one integer with its format controls; rsp returns the formatted
// field one character per transaction, last set on the final character.
// an accepted request with an unused specifier (6 or 7) produces no output.
// conversion first, then emission:
//   binary, octal, hex: one digit per cycle peeled off the low end of the
//   value into a digit stack
//   decimal: bit-serial double dabble into a bcd register,
//   then the bcd digits are moved into the digit stack
// emission: one character per cycle from the output register, up to 64 in a
// field, when the receiver never stalls. a stalled receiver
// holds the output register and freezes emission.
// the next request is taken once the last character is in the output register,
// even while it still waits. arst_n clears the control state; no clearing
// pass is needed.
module integer_to_ascii_formatter_top #(
	parameter int MAX_WIDTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	ifmt_stream_if.sink   req,
	ifmt_stream_if.source rsp
);
	import ifmt_pkg::*;

	localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

	state_t st_q;
	logic [BCD_W-1:0] val_q;
	logic [63:0] bin_q;
	logic [5:0] bit_cnt_q;
	logic [2:0] func_q;
	logic [6:0] wsat_q;
	logic la_q, zp_q, sign_q;
	logic [6:0] nd_q, pad_q, rem_q;
	logic [3:0] stk_q [DIG_DEPTH];
	logic ov_q;
	fmt_rsp_t rsp_q;

	// request decode
	logic accept;
	logic [63:0] v_ext, v_abs;
	logic neg_in;

	assign req.ready = (st_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign v_ext = req.data.long_value ? req.data.value
		: {{32{req.data.value[31]}}, req.data.value[31:0]};
	assign neg_in = (req.data.func == FUNC_SDEC) && v_ext[63];
	assign v_abs = neg_in ? (64'd0 - v_ext) : v_ext;

	// double dabble: add 3 to every bcd digit of 5 or more, then shift
	logic [BCD_W-1:0] bcd_adj;
	always_comb begin
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (val_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = val_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = val_q[4*i +: 4];
		end
	end

	// digit extraction step
	logic [3:0] dig;
	logic [BCD_W-1:0] val_nx;
	logic [6:0] nd_nx, actual, total;
	logic dig_done;

	assign dig = val_q[3:0] & digit_mask(func_q);
	always_comb begin
		case (func_q)
			FUNC_BIN: val_nx = val_q >> 1;
			FUNC_OCT: val_nx = val_q >> 3;
			default:  val_nx = val_q >> 4;
		endcase
	end
	assign nd_nx = nd_q + 7'd1;
	assign dig_done = (val_nx == '0) || (nd_nx == DIG_MAX);
	assign actual = nd_nx + {6'd0, sign_q};
	assign total = (wsat_q > actual) ? wsat_q : actual;

	// emission step
	logic load;
	logic pad_lead, use_sign, pad_zero, use_dig;
	logic [7:0] next_char;

	assign load = (st_q == ST_EMIT) && (!ov_q || rsp.ready);
	assign pad_lead = !la_q && !zp_q && (pad_q != 7'd0);
	assign use_sign = !pad_lead && sign_q;
	assign pad_zero = !pad_lead && !sign_q && zp_q && (pad_q != 7'd0);
	assign use_dig = !pad_lead && !sign_q && !pad_zero && (nd_q != 7'd0);

	always_comb begin
		if (pad_lead)
			next_char = CHAR_SPACE;
		else if (use_sign)
			next_char = CHAR_MINUS;
		else if (pad_zero)
			next_char = CHAR_ZERO;
		else if (use_dig)
			next_char = digit_char(stk_q[0], func_q == FUNC_HEXU);
		else
			next_char = CHAR_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
			nd_q <= '0;
			pad_q <= '0;
			rem_q <= '0;
			sign_q <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			if (rsp.ready && !load)
				ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept && req.data.func <= FUNC_HEXU) begin
						sign_q <= neg_in;
						nd_q <= '0;
						bit_cnt_q <= '1;
						if (req.data.func == FUNC_SDEC || req.data.func == FUNC_UDEC)
							st_q <= ST_DD;
						else
							st_q <= ST_DIG;
					end
				end
				ST_DD: begin
					if (bit_cnt_q == 6'd0)
						st_q <= ST_DIG;
					bit_cnt_q <= bit_cnt_q - 6'd1;
				end
				ST_DIG: begin
					nd_q <= nd_nx;
					if (dig_done) begin
						pad_q <= total - actual;
						rem_q <= total;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						ov_q <= 1'b1;
						rem_q <= rem_q - 7'd1;
						if (use_sign)
							sign_q <= 1'b0;
						else if (use_dig)
							nd_q <= nd_q - 7'd1;
						else
							pad_q <= pad_q - 7'd1;
						if (rem_q == 7'd1)
							st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.data.func;
			wsat_q <= (req.data.width > MaxW) ? MaxW : req.data.width;
			la_q <= req.data.left_adjust;
			zp_q <= req.data.zero_pad && !req.data.left_adjust;
			bin_q <= v_abs;
			if (req.data.func == FUNC_SDEC || req.data.func == FUNC_UDEC)
				val_q <= '0;
			else
				val_q <= {{(BCD_W - 64){1'b0}}, v_abs};
		end else if (st_q == ST_DD) begin
			val_q <= {bcd_adj[BCD_W-2:0], bin_q[63]};
			bin_q <= {bin_q[62:0], 1'b0};
		end else if (st_q == ST_DIG) begin
			val_q <= val_nx;
		end

		// digit stack: push during extraction, pop during emission
		if (st_q == ST_DIG) begin
			for (int i = DIG_DEPTH - 1; i > 0; i--)
				stk_q[i] <= stk_q[i-1];
			stk_q[0] <= dig;
		end else if (load && use_dig) begin
			for (int i = 0; i < DIG_DEPTH - 1; i++)
				stk_q[i] <= stk_q[i+1];
		end

		if (load) begin
			rsp_q.out_char <= next_char;
			rsp_q.last <= (rem_q == 7'd1);
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.data = rsp_q;

	`include "assert_macros.svh"

	// digits left never exceed characters left
	`ASSERT_IMPL(a_nd_le_rem, st_q == ST_EMIT, nd_q <= rem_q)
	// a pending minus always has digits behind it
	`ASSERT_IMPL(a_sign_has_digits, st_q == ST_EMIT && sign_q, nd_q != 7'd0)
	// emission never runs on an empty field
	`ASSERT_IMPL(a_emit_nonempty, st_q == ST_EMIT, rem_q != 7'd0)

endmodule

/* test/ifmt_field_checker.sv */
// monitors the request and response channels of the integer to ascii formatter,
// predicts every formatted field and compares it character by character
// depends on ifmt_pkg
`timescale 1ns / 100ps

module ifmt_field_checker #(
	parameter int FIELD_MAX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  ifmt_pkg::fmt_req_t req_data,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  ifmt_pkg::fmt_rsp_t rsp_data,
	input  logic               end_of_run,
	output int                 mismatches,
	output int                 chars_pending,
	output int                 chars_checked,
	output int                 fields_expected
);
	import ifmt_pkg::*;

	fmt_rsp_t field_chars_q[$];

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly off
		if (mismatches < 40)
			$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [63:0] radix_for(input logic [2:0] func);
		logic [63:0] base;
		case (func)
			FUNC_BIN:             base = 64'd2;
			FUNC_OCT:             base = 64'd8;
			FUNC_HEXL, FUNC_HEXU: base = 64'd16;
			default:              base = 64'd10;
		endcase
		return base;
	endfunction

	// queues the characters one request should produce
	function automatic void format_field(input fmt_req_t r);
		logic [63:0] v;
		logic [63:0] base;
		logic [3:0]  rem;
		logic        neg;
		logic        zeros;
		logic [7:0]  digs[$];
		logic [7:0]  text[$];
		fmt_rsp_t    c;
		int          w;
		int          actual;
		int          total;
		int          i;
		if (r.func > FUNC_HEXU)
			return;
		v = r.long_value ? r.value : {{32{r.value[31]}}, r.value[31:0]};
		neg = (r.func == FUNC_SDEC) && v[63];
		if (neg)
			v = -v;
		base = radix_for(r.func);
		// digits come out least significant first
		do begin
			rem = 4'(v % base);
			if (rem < DEC_TEN)
				digs.push_back(CHAR_ZERO + 8'(rem));
			else if (r.func == FUNC_HEXU)
				digs.push_back(CHAR_UA + 8'(rem - DEC_TEN));
			else
				digs.push_back(CHAR_LA + 8'(rem - DEC_TEN));
			v = v / base;
		end while (v != 0);
		actual = digs.size() + (neg ? 1 : 0);
		w = (int'(r.width) > FIELD_MAX) ? FIELD_MAX : int'(r.width);
		total = (w > actual) ? w : actual;
		zeros = r.zero_pad && !r.left_adjust;
		if (!r.left_adjust && !zeros)
			for (i = actual; i < total; i++)
				text.push_back(CHAR_SPACE);
		if (neg)
			text.push_back(CHAR_MINUS);
		if (zeros)
			for (i = actual; i < total; i++)
				text.push_back(CHAR_ZERO);
		for (i = digs.size() - 1; i >= 0; i--)
			text.push_back(digs[i]);
		if (r.left_adjust)
			for (i = actual; i < total; i++)
				text.push_back(CHAR_SPACE);
		for (i = 0; i < text.size(); i++) begin
			c.out_char = text[i];
			c.last = (i == text.size() - 1);
			field_chars_q.push_back(c);
		end
		fields_expected++;
	endfunction

	always @(posedge clk) begin : monitor
		fmt_rsp_t want;
		if (!arst_n) begin
			field_chars_q.delete();
			mismatches = 0;
			chars_checked = 0;
			fields_expected = 0;
		end else begin
			// responses first: a field never starts in the cycle its request is taken
			if (rsp_valid && rsp_ready) begin
				if (field_chars_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character 8'h%h last %b",
						rsp_data.out_char, rsp_data.last));
				end else begin
					want = field_chars_q.pop_front();
					chars_checked++;
					if (rsp_data.out_char !== want.out_char)
						report_mismatch($sformatf("out_char 8'h%h, predicted 8'h%h",
							rsp_data.out_char, want.out_char));
					if (rsp_data.last !== want.last)
						report_mismatch($sformatf("last %b, predicted %b on char 8'h%h",
							rsp_data.last, want.last, want.out_char));
				end
			end
			if (req_valid && req_ready)
				format_field(req_data);
			if (end_of_run && field_chars_q.size() != 0) begin
				report_mismatch($sformatf("%0d predicted characters never arrived",
					field_chars_q.size()));
				field_chars_q.delete();
			end
		end
		chars_pending = field_chars_q.size();
	end

endmodule

/* test/integer_to_ascii_formatter_top_tb.sv */
// top of the integer to ascii formatter testbench: clock, reset, request stimulus,
// response back-pressure and the verdict
// depends on ifmt_pkg, ifmt_stream_if, integer_to_ascii_formatter_top, ifmt_field_checker
`timescale 1ns / 100ps

module integer_to_ascii_formatter_top_tb;
	import ifmt_pkg::*;

	localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 138;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic no_idle;
	logic end_of_run;
	int   mismatches;
	int   chars_pending;
	int   chars_checked;
	int   fields_expected;
	int   requests_sent;

	ifmt_stream_if #(.payload_t(fmt_req_t)) req_if ();
	ifmt_stream_if #(.payload_t(fmt_rsp_t)) rsp_if ();

	integer_to_ascii_formatter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ifmt_field_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_if.valid),
		.req_ready       (req_if.ready),
		.req_data        (req_if.data),
		.rsp_valid       (rsp_if.valid),
		.rsp_ready       (rsp_if.ready),
		.rsp_data        (rsp_if.data),
		.end_of_run      (end_of_run),
		.mismatches      (mismatches),
		.chars_pending   (chars_pending),
		.chars_checked   (chars_checked),
		.fields_expected (fields_expected)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
	end

	function automatic fmt_req_t make_req(input logic [2:0] func, input logic [63:0] value,
		input logic long_value, input logic [6:0] width, input logic left_adjust,
		input logic zero_pad);
		fmt_req_t r;
		r.func = func;
		r.value = value;
		r.long_value = long_value;
		r.width = width;
		r.left_adjust = left_adjust;
		r.zero_pad = zero_pad;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_request(input fmt_req_t r);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("timeout with %0d characters outstanding", chars_pending);
		$display("FAILURE");
		$finish;
	end

	initial begin
		fmt_req_t    r;
		logic [63:0] v;
		int          i;
		arst_n = 1'b0;
		no_idle = 1'b0;
		end_of_run = 1'b0;
		requests_sent = 0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corner cases
		send_request(make_req(FUNC_BIN, 64'd0, 1'b1, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_BIN, '1, 1'b1, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_SDEC, 64'h8000_0000_0000_0000, 1'b1, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_SDEC, '1, 1'b0, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_SDEC, 64'h7fff_ffff_ffff_ffff, 1'b1, 7'd25, 1'b0, 1'b1));
		send_request(make_req(FUNC_SDEC, 64'h0000_0000_ffff_ffd6, 1'b0, 7'd8, 1'b0, 1'b1));
		send_request(make_req(FUNC_SDEC, 64'h0000_0000_ffff_ffd6, 1'b0, 7'd8, 1'b0, 1'b0));
		send_request(make_req(FUNC_SDEC, 64'h0000_0000_ffff_ffd6, 1'b0, 7'd8, 1'b1, 1'b1));
		send_request(make_req(FUNC_SDEC, 64'hffff_ffff_8000_0000, 1'b1, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_OCT, '1, 1'b1, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_OCT, 64'd8, 1'b0, 7'd127, 1'b0, 1'b0));
		send_request(make_req(FUNC_UDEC, '1, 1'b1, 7'd20, 1'b0, 1'b0));
		send_request(make_req(FUNC_UDEC, 64'h0000_0000_ffff_ffff, 1'b0, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_UDEC, 64'h0000_0000_7fff_ffff, 1'b0, 7'd10, 1'b0, 1'b1));
		send_request(make_req(FUNC_HEXL, 64'h0000_0000_ffff_ffff, 1'b0, 7'd0, 1'b0, 1'b0));
		send_request(make_req(FUNC_HEXU, 64'hdead_beef_0123_abcd, 1'b1, 7'd65, 1'b1, 1'b0));
		send_request(make_req(FUNC_HEXL, 64'h0123_4567_89ab_cdef, 1'b1, 7'd64, 1'b0, 1'b1));
		send_request(make_req(FUNC_HEXU, 64'd0, 1'b1, 7'd1, 1'b0, 1'b0));
		send_request(make_req(FUNC_SDEC, 64'd0, 1'b1, 7'd64, 1'b1, 1'b0));
		send_request(make_req(FUNC_BIN, 64'h0000_0000_8000_0000, 1'b0, 7'd64, 1'b0, 1'b1));
		send_request(make_req(FUNC_SPARE_6, '1, 1'b1, 7'd10, 1'b0, 1'b0));
		send_request(make_req(FUNC_SPARE_7, 64'd5, 1'b0, 7'd0, 1'b1, 1'b1));

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// one long stretch with both sides always willing
			no_idle <= (i >= 60 && i < 110);
			v = {$urandom(), $urandom()};
			case ($urandom_range(0, 3))
				0:       v = v;
				1:       v = v >> $urandom_range(1, 63);
				2:       v = -(v >> $urandom_range(33, 63));
				default: v = v >> $urandom_range(40, 63);
			endcase
			r.func = ($urandom_range(0, 99) < 6) ? 3'($urandom_range(FUNC_SPARE_6, FUNC_SPARE_7))
				: 3'($urandom_range(FUNC_BIN, FUNC_HEXU));
			r.value = v;
			r.long_value = 1'($urandom_range(0, 1));
			r.width = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 24))
				: 7'($urandom_range(0, 127));
			r.left_adjust = 1'($urandom_range(0, 1));
			r.zero_pad = 1'($urandom_range(0, 1));
			send_request(r);
		end
		req_if.valid <= 1'b0;
		no_idle <= 1'b0;

		while (chars_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		end_of_run <= 1'b1;
		@(negedge clk);

		$display("%0d requests sent across all specifiers, spare codes and field widths",
			requests_sent);
		$display("%0d fields predicted, %0d characters compared", fields_expected,
			chars_checked);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
